@@ hdl/utfn_pkg.sv @@
`default_nettype none

package utfn_pkg;

   localparam int ByteW         = 8;
   localparam int CodeW         = 21;
   localparam int SlotsPerPiece = 5;
   localparam int PieceCount    = 3;
   localparam int SlotCount     = SlotsPerPiece * PieceCount;

   localparam logic [ByteW-1:0] SpaceChar = 8'h20;

   // Output of one decoded code point: a leading collapsed space in slot 0 and
   // up to four text bytes above it, each with its own valid bit.
   typedef struct packed {
      logic [SlotsPerPiece-1:0][ByteW-1:0] data;
      logic [SlotsPerPiece-1:0]            valid;
      logic                                after_space;
      logic                                space_pending;
   } piece_type;

   // Everything one item leaves for the result buffer.
   typedef struct packed {
      logic [SlotCount-1:0][ByteW-1:0] data;
      logic [SlotCount-1:0]            mask;
      logic                            last;
      logic                            marker;
   } load_type;

   typedef struct packed {
      logic empty;
      logic drain;
   } buf_status_type;

   // Length of the sequence that a lead byte opens; a stray byte stands alone.
   function automatic logic [2:0] lead_len(logic [ByteW-1:0] b);
      logic [2:0] len;
      len = 3'd1;
      if (b[7:5] == 3'b110) begin
         len = 3'd2;
      end else if (b[7:4] == 4'b1110) begin
         len = 3'd3;
      end else if (b[7:3] == 5'b11110) begin
         len = 3'd4;
      end
      return len;
   endfunction

   // ASCII fold of Latin-1 C0..FF, first byte in the low half, zero when absent.
   function automatic logic [15:0] fold_lookup(logic [5:0] idx);
      logic [15:0] f;
      case (idx[4:0]) inside
         [5'd0:5'd5]   : f = {8'h00, "a"};
         5'd6          : f = {"e", "a"};
         5'd7          : f = {8'h00, "c"};
         [5'd8:5'd11]  : f = {8'h00, "e"};
         [5'd12:5'd15] : f = {8'h00, "i"};
         5'd16         : f = {8'h00, "d"};
         5'd17         : f = {8'h00, "n"};
         [5'd18:5'd22] : f = {8'h00, "o"};
         5'd23         : f = 16'h0000;
         5'd24         : f = {8'h00, "o"};
         [5'd25:5'd28] : f = {8'h00, "u"};
         5'd29         : f = {8'h00, "y"};
         5'd30         : f = {"h", "t"};
         5'd31         : f = idx[5] ? {8'h00, "y"} : {"s", "s"};
         default       : f = 16'h0000;
      endcase
      return f;
   endfunction

   // Normalizes one code point and advances the space-collapsing state.
   function automatic piece_type fold_piece(logic en, logic [CodeW-1:0] cp,
                                            logic after_sp, logic pend);
      piece_type         r;
      logic [3:0][7:0]   p;
      logic [3:0]        pv;
      logic              is_sp;
      logic [15:0]       f;
      p     = '0;
      pv    = '0;
      is_sp = 1'b0;
      f     = fold_lookup(cp[5:0]);
      if (cp >= 21'h0000C0 && cp <= 21'h0000FF) begin
         p[0]  = f[7:0];
         p[1]  = f[15:8];
         pv[0] = |f[7:0];
         pv[1] = |f[15:8];
      end else if (cp < 21'h000080) begin
         case (cp[7:0]) inside
            [8'h41:8'h5A] : begin
               p[0]  = cp[7:0] + 8'd32;
               pv[0] = 1'b1;
            end
            [8'h61:8'h7A], [8'h30:8'h39] : begin
               p[0]  = cp[7:0];
               pv[0] = 1'b1;
            end
            8'h20, 8'h09, 8'h0A : is_sp = 1'b1;
            default : ;
         endcase
      end else if (cp < 21'h000800) begin
         p[0] = {3'b110, cp[10:6]};
         p[1] = {2'b10, cp[5:0]};
         pv   = 4'b0011;
      end else if (cp < 21'h010000) begin
         p[0] = {4'b1110, cp[15:12]};
         p[1] = {2'b10, cp[11:6]};
         p[2] = {2'b10, cp[5:0]};
         pv   = 4'b0111;
      end else begin
         p[0] = {5'b11110, cp[20:18]};
         p[1] = {2'b10, cp[17:12]};
         p[2] = {2'b10, cp[11:6]};
         p[3] = {2'b10, cp[5:0]};
         pv   = 4'b1111;
      end
      r.data          = {p, SpaceChar};
      r.valid         = '0;
      r.after_space   = after_sp;
      r.space_pending = pend;
      if (en) begin
         if (is_sp) begin
            if (!after_sp) begin
               r.space_pending = 1'b1;
            end
            r.after_space = 1'b1;
         end else if (|pv) begin
            r.valid         = {pv, pend};
            r.space_pending = 1'b0;
            r.after_space   = 1'b0;
         end
      end
      return r;
   endfunction

endpackage

`default_nettype wire

@@ hdl/utfn_out_buf.sv @@
`default_nettype none

module utfn_out_buf (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      load,
   input  wire utfn_pkg::load_type        load_data,
   output utfn_pkg::buf_status_type       status,
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   output logic [15:0]                    rsp_tdata,  // [7:0] out_byte, [8] byte_valid
   output logic                           rsp_tlast
);

   logic [utfn_pkg::SlotCount-1:0][utfn_pkg::ByteW-1:0] data_ff;
   logic [utfn_pkg::SlotCount-1:0]                      mask_ff, mask_in, rest;
   logic                                                last_ff, marker_ff;
   logic                                                marker_in;
   logic [utfn_pkg::ByteW-1:0]                          sel_byte;
   logic                                                xfer;

   // Lowest valid slot goes out first; the rest mask drops it.
   always_comb begin
      sel_byte = '0;
      for (int i = utfn_pkg::SlotCount - 1; i >= 0; i--) begin
         if (mask_ff[i]) begin
            sel_byte = data_ff[i];
         end
      end
   end

   assign rest       = mask_ff & (mask_ff - utfn_pkg::SlotCount'(1));
   assign rsp_tvalid = (|mask_ff) | marker_ff;
   assign rsp_tdata  = {7'b0, |mask_ff, sel_byte};
   assign rsp_tlast  = last_ff & (rest == '0);
   assign xfer       = rsp_tvalid & rsp_tready;

   assign status.empty = !rsp_tvalid;
   assign status.drain = xfer & (rest == '0);

   always_comb begin
      mask_in   = mask_ff;
      marker_in = marker_ff;
      if (load) begin
         mask_in   = load_data.mask;
         marker_in = load_data.marker;
      end else if (xfer) begin
         mask_in   = rest;
         marker_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff   <= '0;
         marker_ff <= 1'b0;
         last_ff   <= 1'b0;
      end else begin
         mask_ff   <= mask_in;
         marker_ff <= marker_in;
         if (load) begin
            last_ff <= load_data.last;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data.data;
      end
   end

   a_marker_alone : assert property (@(posedge clock) disable iff (reset)
      !(marker_ff && (|mask_ff)))
      else $error("end-only marker shares the buffer with text bytes");

   a_load_when_free : assert property (@(posedge clock) disable iff (reset)
      load |-> (status.empty || status.drain))
      else $error("buffer loaded while results still wait");

   a_drain_order : assert property (@(posedge clock) disable iff (reset)
      (xfer && !load && (rest != '0)) |=> (mask_ff == $past(rest)))
      else $error("buffer did not drop exactly the byte just sent");

endmodule

`default_nettype wire

@@ hdl/utf8_text_fold_normalizer.sv @@
// An input byte is taken into the input register, moves into the result buffer
// once that is empty or sending its final byte, and its results are offered from there.
// Throughput: one input byte per cycle while each byte yields at most one result
// and the receiver is ready; a byte that yields several results (up to 7) keeps the
// result buffer until its last is sent, and the next byte waits meanwhile.
// Reset (synchronous, active high) empties both registers and returns the decoder
// to its start-of-string state: no sequence open, leading spaces suppressed.
`default_nettype none

module utf8_text_fold_normalizer (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] in_byte
   input  wire logic        req_tlast,   // in_last
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // [7:0] out_byte, [8] byte_valid, rest zero
   output logic             rsp_tlast    // out_last
);

   // Input register: one raw byte and its end-of-string mark.
   logic                        item_valid_ff;
   logic [utfn_pkg::ByteW-1:0]  item_byte_ff;
   logic                        item_last_ff;

   // Decoder state carried between bytes of a string.
   logic [utfn_pkg::CodeW-1:0]  accum_ff, accum_in, accum_next;
   logic [2:0]                  seq_len_ff, seq_len_in;
   logic [1:0]                  seen_ff, seen_in;
   logic                        after_space_ff, after_space_in;
   logic                        space_pending_ff, space_pending_in;
   logic [utfn_pkg::ByteW-1:0]  held_ff [4];
   logic [utfn_pkg::ByteW-1:0]  held_view [4];

   logic                        held_we;
   logic [1:0]                  held_idx;
   logic [2:0]                  len_b;
   logic                        have_a, tail, combine;
   logic [utfn_pkg::CodeW-1:0]  cp_done, cp_a, cp_b, cp_c;
   logic                        en_a, en_b, en_c;
   utfn_pkg::piece_type         res_a, res_b, res_c;
   utfn_pkg::load_type          load_data;
   utfn_pkg::buf_status_type    buf_status;
   logic                        advance;

   // The item moves on once the result buffer is empty or sends its final byte
   // in this cycle, so the input register frees up in the same cycle.
   assign advance    = item_valid_ff & (buf_status.empty | buf_status.drain);
   assign req_tready = !item_valid_ff | advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (req_tready) begin
         item_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         item_byte_ff <= req_tdata[7:0];
         item_last_ff <= req_tlast;
      end
   end

   // Sequence tracking. A lead byte opens a sequence and keeps its payload bits;
   // every further byte adds its low six bits until the sequence is complete.
   always_comb begin
      len_b      = utfn_pkg::lead_len(item_byte_ff);
      seq_len_in = seq_len_ff;
      seen_in    = seen_ff;
      accum_in   = accum_ff;
      accum_next = {accum_ff[14:0], item_byte_ff[5:0]};
      held_we    = 1'b0;
      held_idx   = seen_ff;
      cp_done    = {13'b0, item_byte_ff};
      have_a     = 1'b0;
      if (seq_len_ff == 3'd0) begin
         if (len_b == 3'd1) begin
            have_a = 1'b1;
         end else begin
            seq_len_in = len_b;
            seen_in    = 2'd1;
            held_we    = 1'b1;
            held_idx   = 2'd0;
            case (len_b)
               3'd2    : accum_in = {16'b0, item_byte_ff[4:0]};
               3'd3    : accum_in = {17'b0, item_byte_ff[3:0]};
               default : accum_in = {18'b0, item_byte_ff[2:0]};
            endcase
         end
      end else begin
         held_we = 1'b1;
         if (({1'b0, seen_ff} + 3'd1) >= seq_len_ff) begin
            cp_done    = accum_next;
            have_a     = 1'b1;
            seq_len_in = 3'd0;
            seen_in    = 2'd0;
            accum_in   = '0;
         end else begin
            seen_in  = seen_ff + 2'd1;
            accum_in = accum_next;
         end
      end
   end

   // Held bytes as they stand once this byte is written.
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         held_view[i] = (held_we && (held_idx == 2'(i))) ? item_byte_ff : held_ff[i];
      end
   end

   // A string that ends inside a sequence: the lead byte stands alone, and the
   // bytes after it are parsed again. Only a two-byte lead in the middle position
   // can still find its continuation byte; anything else stands for itself.
   always_comb begin
      tail    = item_last_ff & (seq_len_in != 3'd0);
      combine = (seen_in == 2'd3) & (utfn_pkg::lead_len(held_view[1]) == 3'd2);
      en_a    = have_a | tail;
      en_b    = tail & (seen_in >= 2'd2);
      en_c    = tail & (seen_in == 2'd3) & !combine;
      cp_a    = tail ? {13'b0, held_view[0]} : cp_done;
      cp_b    = combine ? {10'b0, held_view[1][4:0], held_view[2][5:0]}
                        : {13'b0, held_view[1]};
      cp_c    = {13'b0, held_view[2]};
   end

   // Up to three code points are normalized in order, the space state passing
   // from one to the next.
   assign res_a = utfn_pkg::fold_piece(en_a, cp_a, after_space_ff, space_pending_ff);
   assign res_b = utfn_pkg::fold_piece(en_b, cp_b, res_a.after_space, res_a.space_pending);
   assign res_c = utfn_pkg::fold_piece(en_c, cp_c, res_b.after_space, res_b.space_pending);

   always_comb begin
      load_data.data   = {res_c.data, res_b.data, res_a.data};
      load_data.mask   = {res_c.valid, res_b.valid, res_a.valid};
      load_data.last   = item_last_ff;
      load_data.marker = item_last_ff & ({res_c.valid, res_b.valid, res_a.valid} == '0);
      after_space_in   = res_c.after_space;
      space_pending_in = res_c.space_pending;
   end

   // At the end of a string the trailing space is dropped and every piece of
   // decoder state goes back to its start-of-string value.
   always_ff @(posedge clock) begin
      if (reset) begin
         seq_len_ff       <= 3'd0;
         seen_ff          <= 2'd0;
         accum_ff         <= '0;
         after_space_ff   <= 1'b1;
         space_pending_ff <= 1'b0;
      end else if (advance) begin
         if (item_last_ff) begin
            seq_len_ff       <= 3'd0;
            seen_ff          <= 2'd0;
            accum_ff         <= '0;
            after_space_ff   <= 1'b1;
            space_pending_ff <= 1'b0;
         end else begin
            seq_len_ff       <= seq_len_in;
            seen_ff          <= seen_in;
            accum_ff         <= accum_in;
            after_space_ff   <= after_space_in;
            space_pending_ff <= space_pending_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance && held_we) begin
         held_ff[held_idx] <= item_byte_ff;
      end
   end

   utfn_out_buf u_out_buf (
      .clock      (clock),
      .reset      (reset),
      .load       (advance),
      .load_data  (load_data),
      .status     (buf_status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   a_seq_len_legal : assert property (@(posedge clock) disable iff (reset)
      (seq_len_ff == 3'd0) || (seq_len_ff >= 3'd2 && seq_len_ff <= 3'd4))
      else $error("open sequence has an impossible length");

   a_seen_in_range : assert property (@(posedge clock) disable iff (reset)
      (seq_len_ff != 3'd0) |-> (seen_ff != 2'd0 && {1'b0, seen_ff} < seq_len_ff))
      else $error("byte count of the open sequence out of range");

   a_end_restarts : assert property (@(posedge clock) disable iff (reset)
      (advance && item_last_ff) |=>
         (seq_len_ff == 3'd0 && after_space_ff && !space_pending_ff))
      else $error("decoder state not restarted after the end of a string");

   a_end_has_result : assert property (@(posedge clock) disable iff (reset)
      (advance && item_last_ff) |=> rsp_tvalid)
      else $error("end of string left no result to send");

endmodule

`default_nettype wire

@@ tb/sv/testbench.sv @@
`default_nettype none

module testbench;

   // Upper bound on the run. The slowest correct run offers about 390 bytes, each
   // behind a long sender gap, each producing up to seven result transfers that
   // may each wait out a long receiver stall, plus one long hold-off. The limit
   // leaves ample margin above such a run.
   localparam int CycleLimit    = 400000;
   localparam int HoldCycles    = 300;
   localparam int ItemsPerPhase = 90;
   // Two register stages, plus up to seven results from one byte.
   localparam int SettleCycles  = 12;

   localparam logic [7:0] SpaceByte   = utfn_pkg::SpaceChar;
   localparam logic [7:0] TabByte     = 8'h09;
   localparam logic [7:0] NewlineByte = 8'h0A;

   // One expected result transfer.
   typedef struct {
      logic [7:0] data;
      logic       valid;
      logic       last;
   } text_beat_type;

   // The classes of random text that a string is built from.
   typedef enum int {
      PieceUpper, PieceLower, PieceDigit, PieceBlank, PieceAscii, PieceLatin,
      PieceTwo, PieceThree, PieceFour, PieceHigh, PieceAnyByte
   } piece_kind_type;

   // Predicts the normalized text of each accepted byte and checks the result
   // transfers against it in order.
   class fold_scoreboard;
      text_beat_type expected_beats[$];
      int            error_count;
      logic [20:0]   code_accum;
      logic [2:0]    seq_length;
      logic [1:0]    seq_seen;
      logic [7:0]    held[4];
      bit            after_space;
      bit            space_pending;
      logic [7:0]    step_bytes[$];

      function new();
         error_count = 0;
         foreach (held[i]) held[i] = 8'h00;
         start_string();
      endfunction

      function void start_string();
         code_accum    = '0;
         seq_length    = 3'd0;
         seq_seen      = 2'd0;
         after_space   = 1'b1;
         space_pending = 1'b0;
      endfunction

      function int lead_length(logic [7:0] b);
         if (b[7:5] == 3'b110) return 2;
         if (b[7:4] == 4'b1110) return 3;
         if (b[7:3] == 5'b11110) return 4;
         return 1;
      endfunction

      // ASCII spelling of the Latin-1 letters C0..FF.
      function string latin_fold(logic [5:0] idx);
         logic [4:0] k;
         k = idx[4:0];
         if (k <= 5) return "a";
         if (k == 6) return "ae";
         if (k == 7) return "c";
         if (k <= 11) return "e";
         if (k <= 15) return "i";
         if (k == 16) return "d";
         if (k == 17) return "n";
         if (k <= 22) return "o";
         if (k == 23) return "";
         if (k == 24) return "o";
         if (k <= 28) return "u";
         if (k == 29) return "y";
         if (k == 30) return "th";
         return idx[5] ? "y" : "ss";
      endfunction

      function void take_code_point(logic [20:0] cp);
         logic [7:0] piece[$];
         string      spelled;
         bit         is_space;
         is_space = 1'b0;
         if (cp >= 21'h0000C0 && cp <= 21'h0000FF) begin
            spelled = latin_fold(cp[5:0]);
            for (int i = 0; i < spelled.len(); i++) piece.insert(piece.size(), spelled[i]);
         end else if (cp < 21'h000080) begin
            if (cp >= "A" && cp <= "Z") begin
               piece.insert(piece.size(), cp[7:0] + 8'd32);
            end else if ((cp >= "a" && cp <= "z") || (cp >= "0" && cp <= "9")) begin
               piece.insert(piece.size(), cp[7:0]);
            end else if (cp[7:0] == SpaceByte || cp[7:0] == TabByte ||
                         cp[7:0] == NewlineByte) begin
               is_space = 1'b1;
            end
         end else if (cp < 21'h000800) begin
            piece.insert(piece.size(), {3'b110, cp[10:6]});
            piece.insert(piece.size(), {2'b10, cp[5:0]});
         end else if (cp < 21'h010000) begin
            piece.insert(piece.size(), {4'b1110, cp[15:12]});
            piece.insert(piece.size(), {2'b10, cp[11:6]});
            piece.insert(piece.size(), {2'b10, cp[5:0]});
         end else begin
            piece.insert(piece.size(), {5'b11110, cp[20:18]});
            piece.insert(piece.size(), {2'b10, cp[17:12]});
            piece.insert(piece.size(), {2'b10, cp[11:6]});
            piece.insert(piece.size(), {2'b10, cp[5:0]});
         end

         // A space is only released once real text follows it.
         if (is_space) begin
            if (!after_space) space_pending = 1'b1;
            after_space = 1'b1;
         end else if (piece.size() > 0) begin
            if (space_pending) step_bytes.insert(step_bytes.size(), SpaceByte);
            space_pending = 1'b0;
            foreach (piece[i]) step_bytes.insert(step_bytes.size(), piece[i]);
            after_space = 1'b0;
         end
      endfunction

      // The string ended inside a sequence: decode the held bytes again, and a
      // lead whose sequence no longer fits stands for itself.
      function void reparse_tail(int count);
         int          pos;
         int          len;
         logic [20:0] cp;
         pos = 0;
         while (pos < count) begin
            len = lead_length(held[pos]);
            if (len == 1 || pos + len > count) begin
               take_code_point({13'd0, held[pos]});
               pos++;
            end else begin
               cp = held[pos] & (8'hFF >> (len + 1));
               for (int k = 1; k < len; k++) cp = {cp[14:0], held[pos + k][5:0]};
               take_code_point(cp);
               pos += len;
            end
         end
      endfunction

      function void note_byte(logic [7:0] b, logic is_final);
         int            len;
         int            seen;
         text_beat_type beat;
         step_bytes.delete();
         if (seq_length == 0) begin
            len = lead_length(b);
            if (len == 1) begin
               take_code_point({13'd0, b});
            end else begin
               seq_length = 3'(len);
               seq_seen   = 2'd1;
               held[0]    = b;
               code_accum = b & (8'hFF >> (len + 1));
            end
         end else begin
            seen       = seq_seen;
            held[seen] = b;
            code_accum = {code_accum[14:0], b[5:0]};
            seen++;
            if (seen >= seq_length) begin
               take_code_point(code_accum);
               seq_length = 3'd0;
               seq_seen   = 2'd0;
               code_accum = '0;
            end else begin
               seq_seen = 2'(seen);
            end
         end

         if (is_final && seq_length != 0) reparse_tail(seq_seen);
         foreach (step_bytes[i]) begin
            beat.data  = step_bytes[i];
            beat.valid = 1'b1;
            beat.last  = is_final && (i == step_bytes.size() - 1);
            expected_beats.insert(expected_beats.size(), beat);
         end
         if (is_final) begin
            // A final byte that yields nothing is answered by an end-only marker.
            if (step_bytes.size() == 0) begin
               beat.data  = 8'h00;
               beat.valid = 1'b0;
               beat.last  = 1'b1;
               expected_beats.insert(expected_beats.size(), beat);
            end
            start_string();
         end
      endfunction

      function void check_beat(logic [15:0] tdata, logic tlast);
         text_beat_type want;
         if (expected_beats.size() == 0) begin
            $error("unexpected result: out_byte %h byte_valid %b out_last %b",
                   tdata[7:0], tdata[8], tlast);
            error_count++;
            return;
         end
         want = expected_beats.pop_front();
         if (tdata[7:0] !== want.data) begin
            $error("out_byte: expected %h, actual %h", want.data, tdata[7:0]);
            error_count++;
         end
         if (tdata[8] !== want.valid) begin
            $error("byte_valid: expected %b, actual %b", want.valid, tdata[8]);
            error_count++;
         end
         if (tlast !== want.last) begin
            $error("out_last: expected %b, actual %b", want.last, tlast);
            error_count++;
         end
         if (tdata[15:9] !== 7'd0) begin
            $error("tdata padding: expected %h, actual %h", 7'd0, tdata[15:9]);
            error_count++;
         end
      endfunction
   endclass

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;   // [7:0] in_byte
   logic        req_tlast  = 1'b0;    // in_last
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;            // [7:0] out_byte, [8] byte_valid, [15:9] zero
   logic        rsp_tlast;            // out_last

   fold_scoreboard board = new();

   // Idling of each phase, in cycles of a hundred: none, sender idle, receiver
   // stalling, and both together.
   int idle_by_phase[4]  = '{0, 73, 0, 18};
   int stall_by_phase[4] = '{0, 0, 73, 18};

   int         sender_idle_pct    = 0;
   int         receiver_stall_pct = 0;
   int         hold_left          = 0;
   bit         hold_request       = 1'b0;
   int         cycle_count        = 0;
   int         sent_in_phase      = 0;
   logic [7:0] text_q[$];

   utf8_text_fold_normalizer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Watchdog: a run that stops making progress ends here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CycleLimit) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Receiver. Signals read straight after the edge still hold the values that
   // the edge sampled, so a transfer is seen exactly when the block saw it. A
   // hold-off request keeps tready low for a long stretch, so that the block
   // fills up and stalls its input side while the sender keeps offering.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         board.check_beat(rsp_tdata, rsp_tlast);
      end
      if (hold_request) begin
         hold_request = 1'b0;
         hold_left    = HoldCycles;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   // Offers one byte, with random idle cycles ahead of it, and holds it until
   // the transfer completes. The prediction is updated at acceptance.
   task automatic send_beat(logic [7:0] b, logic is_final);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= is_final;
      do @(posedge clock); while (!req_tready);
      board.note_byte(b, is_final);
      sent_in_phase++;
   endtask

   // Sends the queued string, marking its final byte.
   task automatic send_text();
      foreach (text_q[i]) send_beat(text_q[i], i == text_q.size() - 1);
      text_q.delete();
   endtask

   // Appends one byte to the string being built.
   function automatic void queue_byte(logic [7:0] b);
      text_q.insert(text_q.size(), b);
   endfunction

   // Continuation bytes are mostly well formed, but now and then arbitrary.
   function automatic logic [7:0] cont_byte();
      if ($urandom_range(9) == 0) return 8'($urandom);
      return {2'b10, 6'($urandom)};
   endfunction

   task automatic add_piece(piece_kind_type kind);
      case (kind)
         PieceUpper   : queue_byte(8'($urandom_range(8'h5A, 8'h41)));
         PieceLower   : queue_byte(8'($urandom_range(8'h7A, 8'h61)));
         PieceDigit   : queue_byte(8'($urandom_range(8'h39, 8'h30)));
         PieceBlank   : begin
            case ($urandom_range(2))
               0       : queue_byte(SpaceByte);
               1       : queue_byte(TabByte);
               default : queue_byte(NewlineByte);
            endcase
         end
         PieceAscii   : queue_byte(8'($urandom_range(127)));
         PieceLatin   : begin
            // C3 covers the folded letters, C2 the rest of Latin-1.
            queue_byte(($urandom_range(3) == 0) ? 8'hC2 : 8'hC3);
            queue_byte(cont_byte());
         end
         PieceTwo     : begin
            queue_byte({3'b110, 5'($urandom)});
            queue_byte(cont_byte());
         end
         PieceThree   : begin
            queue_byte({4'b1110, 4'($urandom)});
            repeat (2) queue_byte(cont_byte());
         end
         PieceFour    : begin
            queue_byte({5'b11110, 3'($urandom)});
            repeat (3) queue_byte(cont_byte());
         end
         PieceHigh    : queue_byte(8'($urandom_range(255, 128)));
         default      : queue_byte(8'($urandom));
      endcase
   endtask

   // Builds and sends one random string. Most are made of well-formed pieces;
   // some are blanks only, and some end part-way through a sequence.
   task automatic send_random_string();
      int             pieces;
      int             base_len;
      int             cut;
      piece_kind_type kind;
      pieces = $urandom_range(6, 1);
      if ($urandom_range(9) == 0) begin
         repeat (pieces) add_piece(PieceBlank);
      end else begin
         repeat (pieces) begin
            kind = piece_kind_type'($urandom_range(int'(PieceAnyByte)));
            add_piece(kind);
         end
      end
      if ($urandom_range(4) == 0) begin
         kind     = piece_kind_type'(int'(PieceTwo) + $urandom_range(2));
         base_len = text_q.size();
         add_piece(kind);
         cut = $urandom_range(text_q.size() - base_len - 1, 1);
         repeat (cut) text_q.delete(text_q.size() - 1);
      end
      send_text();
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Capital, punctuation, a tab that becomes a space, and a digit.
      text_q = '{8'h41, 8'h2C, TabByte, 8'h39};
      send_text();
      // Latin-1 folds: a two-letter spelling, a sign with no spelling, the last
      // entry of the table, and the highest two-byte code point re-encoded.
      text_q = '{8'hC3, 8'h86, 8'hC3, 8'h97, 8'hC3, 8'hBF, 8'hDF, 8'hBF};
      send_text();
      // A three-byte sequence and the largest four-byte one.
      text_q = '{8'hE2, 8'h82, 8'hAC, 8'hF7, 8'hBF, 8'hBF, 8'hBF};
      send_text();
      // Leading space, then the string ends inside a four-byte sequence whose
      // held bytes decode again as a lone lead and a two-byte letter.
      text_q = '{SpaceByte, 8'hF0, 8'hC3, 8'hA9};
      send_text();
      // A trailing space: the final byte yields nothing, so an end-only marker.
      text_q = '{8'h78, SpaceByte};
      send_text();

      for (int p = 0; p < 4; p++) begin
         sender_idle_pct    = idle_by_phase[p];
         receiver_stall_pct = stall_by_phase[p];
         sent_in_phase      = 0;
         if (p == 0) hold_request = 1'b1;
         while (sent_in_phase < ItemsPerPhase) send_random_string();
      end
      req_tvalid <= 1'b0;

      // Let the receiver drain everything still owed, then a little longer to
      // catch any stray transfer.
      receiver_stall_pct = 0;
      while (board.expected_beats.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);

      if (board.error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

`default_nettype wire

@@ filelist.f @@
hdl/utfn_pkg.sv
hdl/utfn_out_buf.sv
hdl/utf8_text_fold_normalizer.sv
tb/sv/testbench.sv
